// ===== sv/ndac_pkg.sv =====
// Shared types, constants and helper functions for the decimal ASCII printer.
// Depends on nothing; every other file imports it.
package ndac_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int VAL_W         = 32;
	localparam int NDIG          = 10;
	localparam int BCD_W         = 4 * NDIG;
	localparam int DAB_STAGES    = 4;
	localparam int DAB_BITS      = VAL_W / DAB_STAGES;
	localparam int FD_W          = 7;
	localparam int IDX_W         = 4;

	localparam logic [31:0]     INT_SAT  = 32'd99999999;
	localparam logic [FD_W-1:0] FD_SCALE = 7'd100;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_POINT = 8'h2e;

	typedef struct packed {
		logic              action;
		logic signed [31:0] value;
	} ndac_req_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} ndac_res_t;

	typedef struct packed {
		logic             fixed;
		logic             neg;
		logic [FD_W-1:0]  fd;
		logic [BCD_W-1:0] bcd;
		logic [VAL_W-1:0] bin;
	} ndac_item_t;

	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
		input logic [DAB_BITS-1:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd;
		for (int s = 0; s < DAB_BITS; s++) begin
			for (int n = 0; n < NDIG; n++) begin
				if (b[n*4 +: 4] >= 4'd5) begin
					b[n*4 +: 4] = b[n*4 +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[DAB_BITS-1-s]};
		end
		return b;
	endfunction

	function automatic logic [3:0] fd_tens(input logic [FD_W-1:0] fd);
		logic [3:0] t;
		t = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (fd >= FD_W'(10 * k)) begin
				t = 4'(k);
			end
		end
		return t;
	endfunction

endpackage

// ===== sv/ndac_front.sv =====
// Entry stage: magnitude, clamp, saturation and fraction digits, registered.
// Depends on ndac_pkg.
module ndac_front import ndac_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ndac_req_t  req,
	output logic       in_ready,
	output logic       out_valid,
	output ndac_item_t out_item,
	input  logic       out_ready
);

	logic                   valid_s1;
	ndac_item_t             item_s1;
	ndac_item_t             item_d;
	logic [VAL_W-1:0]       raw;
	logic                   neg;
	logic [VAL_W-1:0]       mag;
	logic [VAL_W-1:0]       fv;
	logic [VAL_W-1:0]       ipart;
	logic [FRAC_BITS+6:0]   prod;

	always_comb begin
		raw   = VAL_W'(req.value);
		neg   = raw[VAL_W-1];
		mag   = neg ? (~raw + VAL_W'(1)) : raw;
		fv    = neg ? '0 : raw;
		ipart = fv >> FRAC_BITS;
		if (ipart > INT_SAT) begin
			ipart = INT_SAT;
		end
		prod  = (FRAC_BITS+7)'(fv[FRAC_BITS-1:0]) * (FRAC_BITS+7)'(FD_SCALE);
		item_d.fixed = req.action;
		item_d.neg   = !req.action && neg;
		item_d.fd    = req.action ? prod[FRAC_BITS+6:FRAC_BITS] : '0;
		item_d.bcd   = '0;
		item_d.bin   = req.action ? ipart : mag;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== sv/ndac_dabble.sv =====
// One double-dabble stage: folds DAB_BITS binary bits into the BCD word.
// Depends on ndac_pkg.
module ndac_dabble import ndac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ndac_item_t in_item,
	output logic       in_ready,
	output logic       out_valid,
	output ndac_item_t out_item,
	input  logic       out_ready
);

	logic       valid_sn;
	ndac_item_t item_sn;

	assign in_ready  = !valid_sn || out_ready;
	assign out_valid = valid_sn;
	assign out_item  = item_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (in_ready) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_sn.fixed <= in_item.fixed;
			item_sn.neg   <= in_item.neg;
			item_sn.fd    <= in_item.fd;
			item_sn.bcd   <= dabble_step(in_item.bcd, in_item.bin[VAL_W-1 -: DAB_BITS]);
			item_sn.bin   <= in_item.bin << DAB_BITS;
		end
	end

endmodule

// ===== sv/ndac_ser.sv =====
// Character serialiser: one ASCII beat per cycle from a converted number.
// Depends on ndac_pkg.
module ndac_ser import ndac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ndac_item_t in_item,
	output logic       in_ready,
	output logic       strobe,
	output ndac_res_t  result
);

	typedef enum logic [2:0] {S_IDLE, S_SIGN, S_DIG, S_POINT, S_TENS, S_UNITS} state_t;

	state_t           state_q;
	logic [BCD_W-1:0] bcd_q;
	logic             fixed_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       tens_q;
	logic [3:0]       units_q;
	logic             strobe_q;
	ndac_res_t        result_q;

	logic             finishing;
	logic             load;
	logic [IDX_W-1:0] top_idx;
	logic [3:0]       tens_d;
	logic [3:0]       cur_dig;

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (in_item.bcd[i*4 +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
		tens_d  = fd_tens(in_item.fd);
		cur_dig = bcd_q[idx_q*4 +: 4];
	end

	assign finishing = (state_q == S_UNITS) ||
		(state_q == S_DIG && idx_q == '0 && !fixed_q);
	assign in_ready  = (state_q == S_IDLE) || finishing;
	assign load      = in_ready && in_valid;
	assign strobe    = strobe_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q != S_IDLE);
			case (state_q)
				S_SIGN: begin
					result_q <= '{character: CH_MINUS, last: 1'b0};
					state_q  <= S_DIG;
				end
				S_DIG: begin
					result_q <= '{character: 8'(CH_ZERO + 8'(cur_dig)),
						last: !fixed_q && idx_q == '0};
					if (idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end else if (fixed_q) begin
						state_q <= S_POINT;
					end else if (!load) begin
						state_q <= S_IDLE;
					end
				end
				S_POINT: begin
					result_q <= '{character: CH_POINT, last: 1'b0};
					state_q  <= S_TENS;
				end
				S_TENS: begin
					result_q <= '{character: 8'(CH_ZERO + 8'(tens_q)), last: 1'b0};
					state_q  <= S_UNITS;
				end
				S_UNITS: begin
					result_q <= '{character: 8'(CH_ZERO + 8'(units_q)), last: 1'b1};
					if (!load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (!load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
			if (load) begin
				bcd_q   <= in_item.bcd;
				fixed_q <= in_item.fixed;
				idx_q   <= top_idx;
				tens_q  <= tens_d;
				units_q <= 4'(in_item.fd - FD_W'(7'd10 * FD_W'(tens_d)));
				state_q <= in_item.neg ? S_SIGN : S_DIG;
			end
		end
	end

endmodule

// ===== sv/number_to_decimal_ascii_core.sv =====
// Top level of the decimal ASCII printer: entry stage, four dabble stages, serialiser.
// Depends on ndac_pkg, ndac_front, ndac_dabble and ndac_ser.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  request  | start / busy         | ndac_req_t (action, value)
//  result   | strobe, one cycle    | ndac_res_t (character, last)
//
// Each number yields 1 to 11 character beats, one per cycle; the serialiser sets
// the rate, and it can load the next number while it prints the last beat of one.
// Before its first character, a number passes the entry stage, the dabble stages and the serialiser load.
// Reset clears all valid bits and the serialiser state; no clearing pass.
// Results cannot be held off; busy rises when the pipeline backs up behind the
// serialiser.
module number_to_decimal_ascii_core import ndac_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ndac_req_t request,
	output logic      busy,
	output logic      strobe,
	output ndac_res_t result
);

	logic       front_ready;
	logic       v   [DAB_STAGES+1];
	ndac_item_t it  [DAB_STAGES+1];
	logic       rdy [DAB_STAGES+1];

	ndac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.req       (request),
		.in_ready  (front_ready),
		.out_valid (v[0]),
		.out_item  (it[0]),
		.out_ready (rdy[0])
	);

	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
		ndac_dabble u_dab (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[g]),
			.in_item   (it[g]),
			.in_ready  (rdy[g]),
			.out_valid (v[g+1]),
			.out_item  (it[g+1]),
			.out_ready (rdy[g+1])
		);
	end

	ndac_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v[DAB_STAGES]),
		.in_item  (it[DAB_STAGES]),
		.in_ready (rdy[DAB_STAGES]),
		.strobe   (strobe),
		.result   (result)
	);

	assign busy = !front_ready;

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("character run broken before its last beat");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v[0])
		else $error("accepted request did not enter the entry stage");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.character >= CH_ZERO && result.character <= 8'h39) ||
			result.character == CH_MINUS || result.character == CH_POINT))
		else $error("illegal character on result");

endmodule

// ===== dv/number_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for number_to_decimal_ascii_core: drives numbers in both print modes
// and checks every character beat against a predicted decimal text.
// Depends on ndac_pkg and the core RTL.
module number_to_decimal_ascii_core_tb;
	import ndac_pkg::*;

	localparam int   FRAC      = FRAC_BITS_DEF;
	localparam logic ACT_INT   = 1'b0;
	localparam logic ACT_FIXED = 1'b1;

	class decimal_text_board;
		ndac_res_t  pending_chars[$];
		logic [7:0] text[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		function void add_unsigned(input logic [31:0] mag);
			logic [7:0] digs[$];
			if (mag == 0) begin
				text.push_back(CH_ZERO);
				return;
			end
			while (mag != 0) begin
				digs.push_front(CH_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end
			foreach (digs[i]) text.push_back(digs[i]);
		endfunction

		function void note(input ndac_req_t req);
			logic [31:0] raw;
			logic [31:0] v;
			logic [31:0] ipart;
			logic [31:0] frac;
			logic [31:0] fd;
			logic [63:0] scaled;
			ndac_res_t   r;
			text.delete();
			raw = req.value;
			if (req.action == ACT_INT) begin
				if (raw[31]) begin
					text.push_back(CH_MINUS);
					raw = -raw;
				end
				add_unsigned(raw);
			end else begin
				v      = raw[31] ? 32'd0 : raw;
				ipart  = v >> FRAC;
				frac   = v & ((32'd1 << FRAC) - 32'd1);
				scaled = (64'(frac) * 64'd100) >> FRAC;
				fd     = scaled[31:0];
				if (ipart > INT_SAT) ipart = INT_SAT;
				if (fd > 32'd99) fd = 32'd99;
				add_unsigned(ipart);
				text.push_back(CH_POINT);
				text.push_back(CH_ZERO + 8'(fd / 10));
				text.push_back(CH_ZERO + 8'(fd % 10));
			end
			foreach (text[i]) begin
				r.character = text[i];
				r.last      = (i == text.size() - 1);
				pending_chars.push_back(r);
			end
		endfunction

		task check(input ndac_res_t got);
			ndac_res_t exp_c;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected beat char=%h last=%b", got.character, got.last));
				return;
			end
			exp_c = pending_chars.pop_front();
			if (got.character !== exp_c.character)
				report($sformatf("char %h, expected %h", got.character, exp_c.character));
			if (got.last !== exp_c.last)
				report($sformatf("last %b, expected %b (char %h)", got.last, exp_c.last,
					exp_c.character));
		endtask

		task close_out();
			if (pending_chars.size() != 0)
				report($sformatf("%0d characters never arrived", pending_chars.size()));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	ndac_req_t         request;
	logic              busy;
	logic              strobe;
	ndac_res_t         result;
	logic              gaps_on;
	decimal_text_board sb;

	number_to_decimal_ascii_core #(.FRAC_BITS(FRAC)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe) sb.check(result);
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task send_number(input logic act, input logic [31:0] val);
		logic taken;
		if (gaps_on) begin
			while ($urandom_range(99) < 20) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start          = 1'b1;
		request.action = act;
		request.value  = val;
		taken          = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		sb.note(request);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(31);
			2: v = $urandom_range(999);
			default: v = -($urandom >> $urandom_range(31));
		endcase
		return v;
	endfunction

	initial begin
		#(12 * 200000);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clk     = 1'b0;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		gaps_on = 1'b1;
		sb      = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_number(ACT_INT, 32'd0);
		send_number(ACT_INT, 32'd1);
		send_number(ACT_INT, 32'hffffffff);
		send_number(ACT_INT, 32'd9);
		send_number(ACT_INT, 32'd10);
		send_number(ACT_INT, 32'd100);
		send_number(ACT_INT, -32'd10);
		send_number(ACT_INT, 32'd1000000000);
		send_number(ACT_INT, 32'h7fffffff);
		send_number(ACT_INT, 32'h80000000);
		send_number(ACT_FIXED, 32'd0);
		send_number(ACT_FIXED, 32'hffffffff);
		send_number(ACT_FIXED, 32'h80000000);
		send_number(ACT_FIXED, 32'h7fffffff);
		send_number(ACT_FIXED, 32'd1);
		send_number(ACT_FIXED, 32'd3);
		send_number(ACT_FIXED, 32'd26);
		send_number(ACT_FIXED, 32'd255);
		send_number(ACT_FIXED, 32'd256);
		send_number(ACT_FIXED, 32'd2688);
		send_number(ACT_FIXED, 32'h00ffff80);

		for (int i = 0; i < 150; i++) begin
			gaps_on = !(i >= 60 && i < 110);
			send_number(1'($urandom_range(1)), pick_value());
		end
		start = 1'b0;

		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
